FILE: rtl/mck_pkg.sv
// Package for the Morse character keyer.
// Holds the character table, microcode step codes and the control word types.
// No dependencies.
package mck_pkg;

  localparam int unsigned DitW  = 11;
  localparam int unsigned DurW  = 14;
  localparam int unsigned CharW = 8;
  localparam int unsigned PatW  = 8;
  localparam int unsigned LenW  = 4;
  localparam int unsigned UpcW  = 3;

  localparam logic [DitW-1:0] DitReset = 11'd120;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UpcIdle     = 3'd0;
  localparam upc_t UpcDispatch = 3'd1;
  localparam upc_t UpcTone     = 3'd2;
  localparam upc_t UpcGap      = 3'd3;
  localparam upc_t UpcTail     = 3'd4;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_START,
    COND_ANY,
    COND_MORE
  } cond_e;

  typedef enum logic [1:0] {
    DUR_DIT,
    DUR_SYM,
    DUR_TAIL
  } dur_e;

  typedef struct packed {
    logic  load;
    logic  emit;
    logic  tone;
    logic  last;
    logic  shift;
    dur_e  dur_sel;
    cond_e cond;
    upc_t  target;
    upc_t  alt;
  } ucode_t;

  typedef struct packed {
    logic any;
    logic more;
  } dp_status_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] pat;
  } morse_t;

  // Symbols are left-justified, first symbol in the top bit; a one is a dash.
  function automatic morse_t morse_lookup(input logic [CharW-1:0] ch);
    morse_t m;
    case (ch)
      8'h27:   m = '{4'd6, 8'b011110_00};
      8'h29:   m = '{4'd6, 8'b101101_00};
      8'h2C:   m = '{4'd6, 8'b110011_00};
      8'h2D:   m = '{4'd6, 8'b100001_00};
      8'h2E:   m = '{4'd6, 8'b010101_00};
      8'h2F:   m = '{4'd5, 8'b10010_000};
      8'h30:   m = '{4'd5, 8'b11111_000};
      8'h31:   m = '{4'd5, 8'b01111_000};
      8'h32:   m = '{4'd5, 8'b00111_000};
      8'h33:   m = '{4'd5, 8'b00011_000};
      8'h34:   m = '{4'd5, 8'b00001_000};
      8'h35:   m = '{4'd5, 8'b00000_000};
      8'h36:   m = '{4'd5, 8'b10000_000};
      8'h37:   m = '{4'd5, 8'b11000_000};
      8'h38:   m = '{4'd5, 8'b11100_000};
      8'h39:   m = '{4'd5, 8'b11110_000};
      8'h3A:   m = '{4'd6, 8'b111000_00};
      8'h3B:   m = '{4'd6, 8'b101010_00};
      8'h3F:   m = '{4'd6, 8'b001100_00};
      8'h41:   m = '{4'd2, 8'b01_000000};
      8'h42:   m = '{4'd4, 8'b1000_0000};
      8'h43:   m = '{4'd4, 8'b1010_0000};
      8'h44:   m = '{4'd3, 8'b100_00000};
      8'h45:   m = '{4'd1, 8'b0_0000000};
      8'h46:   m = '{4'd4, 8'b0010_0000};
      8'h47:   m = '{4'd3, 8'b110_00000};
      8'h48:   m = '{4'd4, 8'b0000_0000};
      8'h49:   m = '{4'd2, 8'b00_000000};
      8'h4A:   m = '{4'd4, 8'b0111_0000};
      8'h4B:   m = '{4'd3, 8'b101_00000};
      8'h4C:   m = '{4'd4, 8'b0100_0000};
      8'h4D:   m = '{4'd2, 8'b11_000000};
      8'h4E:   m = '{4'd2, 8'b10_000000};
      8'h4F:   m = '{4'd3, 8'b111_00000};
      8'h50:   m = '{4'd4, 8'b0110_0000};
      8'h51:   m = '{4'd4, 8'b1101_0000};
      8'h52:   m = '{4'd3, 8'b010_00000};
      8'h53:   m = '{4'd3, 8'b000_00000};
      8'h54:   m = '{4'd1, 8'b1_0000000};
      8'h55:   m = '{4'd3, 8'b001_00000};
      8'h56:   m = '{4'd4, 8'b0001_0000};
      8'h57:   m = '{4'd3, 8'b011_00000};
      8'h58:   m = '{4'd4, 8'b1001_0000};
      8'h59:   m = '{4'd4, 8'b1011_0000};
      8'h5A:   m = '{4'd4, 8'b1100_0000};
      8'h5F:   m = '{4'd6, 8'b001101_00};
      8'h08:   m = '{4'd8, 8'b00000000};
      default: m = '{4'd0, 8'b00000000};
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/mck_seq.sv
// Microcode sequencer of the Morse character keyer.
// Holds the step counter and the control store; depends on mck_pkg.
module mck_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mck_pkg::dp_status_t status_i,
  output mck_pkg::ucode_t    ctl_o,
  output logic               busy_o
);
  import mck_pkg::*;

  upc_t   upc_q, upc_d;
  ucode_t uw;
  logic   take;

  always_comb begin
    unique case (upc_q)
      UpcIdle:     uw = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, DUR_DIT,  COND_START,
                          UpcDispatch, UpcIdle};
      UpcDispatch: uw = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DUR_DIT,  COND_ANY,
                          UpcTone, UpcTail};
      UpcTone:     uw = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, DUR_SYM,  COND_MORE,
                          UpcGap, UpcTail};
      UpcGap:      uw = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DUR_DIT,  COND_ALWAYS,
                          UpcTone, UpcTone};
      UpcTail:     uw = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, DUR_TAIL, COND_ALWAYS,
                          UpcIdle, UpcIdle};
      default:     uw = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DUR_DIT,  COND_ALWAYS,
                          UpcIdle, UpcIdle};
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: take = 1'b1;
      COND_START:  take = start_i;
      COND_ANY:    take = status_i.any;
      COND_MORE:   take = status_i.more;
      default:     take = 1'b0;
    endcase
    upc_d = take ? uw.target : uw.alt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o  = uw;
  assign busy_o = (upc_q != UpcIdle);

endmodule

FILE: rtl/mck_datapath.sv
// Datapath of the Morse character keyer: symbol shifter, counter and segment register.
// Driven by the control word of mck_seq; depends on mck_pkg.
module mck_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mck_pkg::ucode_t              ctl_i,
  input  logic                         start_i,
  input  logic [mck_pkg::CharW-1:0]    char_code_i,
  input  logic                         final_char_i,
  input  logic                         dit_we_i,
  input  logic [mck_pkg::DitW-1:0]     dit_wdata_i,
  output mck_pkg::dp_status_t          status_o,
  output logic                         strobe_o,
  output logic                         tone_on_o,
  output logic [mck_pkg::DurW-1:0]     duration_ms_o,
  output logic                         last_segment_o
);
  import mck_pkg::*;

  logic [DitW-1:0] dit_q;
  logic [PatW-1:0] pat_q;
  logic [LenW-1:0] cnt_q;
  logic            final_q;
  logic            strobe_q;
  logic            tone_q, last_q;
  logic [DurW-1:0] dur_q, dur_d;
  logic [DurW-1:0] d1, d3, d7;
  morse_t          lk;

  assign lk = morse_lookup(char_code_i);
  assign d1 = {{(DurW-DitW){1'b0}}, dit_q};
  assign d3 = (d1 << 1) + d1;
  assign d7 = (d1 << 3) - d1;

  always_comb begin
    case (ctl_i.dur_sel)
      DUR_SYM:  dur_d = pat_q[PatW-1] ? d3 : d1;
      DUR_TAIL: dur_d = final_q ? d7 : d3;
      default:  dur_d = d1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q    <= DitReset;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (dit_we_i) begin
        dit_q <= dit_wdata_i;
      end
      if (ctl_i.load && start_i) begin
        cnt_q <= lk.len;
      end else if (ctl_i.shift) begin
        cnt_q <= cnt_q - 1'b1;
      end
      strobe_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && start_i) begin
      pat_q   <= lk.pat;
      final_q <= final_char_i;
    end else if (ctl_i.shift) begin
      pat_q <= {pat_q[PatW-2:0], 1'b0};
    end
    if (ctl_i.emit) begin
      tone_q <= ctl_i.tone;
      last_q <= ctl_i.last;
      dur_q  <= dur_d;
    end
  end

  assign status_o.any    = (cnt_q != '0);
  assign status_o.more   = (cnt_q > LenW'(1));
  assign strobe_o        = strobe_q;
  assign tone_on_o       = tone_q;
  assign duration_ms_o   = dur_q;
  assign last_segment_o  = last_q;

endmodule

FILE: rtl/morse_character_keyer.sv
// Top level of the Morse character keyer.
// Instantiates mck_seq and mck_datapath; depends on mck_pkg.
//
// A character is taken at a clock edge where start is high and busy is low.
// The character is looked up in a fixed Morse table and sent as a run of
// segments: tones of one or three dits, one-dit gaps between symbols, and a
// trailing silence of three dits, or seven when final_char_i is set.
// Each segment appears on the result ports for one cycle with strobe_o high;
// the receiver cannot stall, so every segment must be taken when shown.
// After the accepting edge the sequencer steps through Dispatch to the first
// segment step, whose segment is registered onto the ports; then one segment
// follows per cycle, and the trailing silence carries last_segment_o. Busy
// stays high for one microcode step to dispatch and one step per segment,
// and is longest for the eight-dot error code.
// The dit length register is written through dit_we_i and dit_wdata_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset returns the sequencer to idle and the dit length to 120 ms.
module morse_character_keyer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mck_pkg::CharW-1:0] char_code_i,
  input  logic                      final_char_i,
  input  logic                      dit_we_i,
  input  logic [mck_pkg::DitW-1:0]  dit_wdata_i,
  output logic                      strobe_o,
  output logic                      tone_on_o,
  output logic [mck_pkg::DurW-1:0]  duration_ms_o,
  output logic                      last_segment_o
);
  import mck_pkg::*;

  ucode_t     ctl;
  dp_status_t status;

  mck_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctl_o    (ctl),
    .busy_o   (busy)
  );

  mck_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .start_i        (start),
    .char_code_i    (char_code_i),
    .final_char_i   (final_char_i),
    .dit_we_i       (dit_we_i),
    .dit_wdata_i    (dit_wdata_i),
    .status_o       (status),
    .strobe_o       (strobe_o),
    .tone_on_o      (tone_on_o),
    .duration_ms_o  (duration_ms_o),
    .last_segment_o (last_segment_o)
  );

endmodule

FILE: rtl/mck_checker.sv
// Port-level checker for the Morse character keyer, bound to the top level.
// Depends on mck_pkg and morse_character_keyer.
module mck_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe_o,
  input logic tone_on_o,
  input logic last_segment_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted item");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !strobe_o)
    else $error("segment shown right after an accepted item");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_segment_o |-> !busy)
    else $error("busy still high on the final segment");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_segment_o |-> busy)
    else $error("segment before the final one shown while idle");

  a_gap_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !tone_on_o && !last_segment_o |=> strobe_o && tone_on_o)
    else $error("symbol gap not followed by a tone");

endmodule

bind morse_character_keyer mck_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .strobe_o       (strobe_o),
  .tone_on_o      (tone_on_o),
  .last_segment_o (last_segment_o)
);

FILE: dv/tb.sv
// Testbench for morse_character_keyer: sends characters, predicts each timed
// segment from its own Morse table and checks every strobed segment in order.
// Depends on mck_pkg and the keyer RTL.
`timescale 1ns / 100ps

module tb;

  typedef logic [mck_pkg::DurW-1:0] dur_t;
  typedef logic [mck_pkg::DitW-1:0] dit_t;
  typedef logic [mck_pkg::CharW-1:0] char_t;

  typedef struct packed {
    logic tone;
    dur_t dur;
    logic last;
  } segment_t;

  localparam int CycleLimit = 150000;
  localparam int SettleCycles = 20;
  localparam char_t AsciiBackspace = 8'h08;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  char_t char_code_i;
  logic final_char_i;
  logic dit_we_i;
  dit_t dit_wdata_i;
  logic strobe_o;
  logic tone_on_o;
  dur_t duration_ms_o;
  logic last_segment_o;

  segment_t segs_due[$];
  dit_t dit_len;
  int fail_count = 0;
  int cycle_count = 0;
  int max_gap = 13;
  string keyed_chars = "'),-./0123456789:;?ABCDEFGHIJKLMNOPQRSTUVWXYZ_ ";

  morse_character_keyer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .char_code_i   (char_code_i),
    .final_char_i  (final_char_i),
    .dit_we_i      (dit_we_i),
    .dit_wdata_i   (dit_wdata_i),
    .strobe_o      (strobe_o),
    .tone_on_o     (tone_on_o),
    .duration_ms_o (duration_ms_o),
    .last_segment_o(last_segment_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic string morse_of(char_t c);
    case (c)
      8'h27: return ".----.";
      ")": return "-.--.-";
      ",": return "--..--";
      "-": return "-....-";
      ".": return ".-.-.-";
      "/": return "-..-.";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      ":": return "---...";
      ";": return "-.-.-.";
      "?": return "..--..";
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "_": return "..--.-";
      AsciiBackspace: return "........";
      default: return "";
    endcase
  endfunction

  task automatic queue_segments_for(char_t c, logic fin);
    string pat;
    dur_t unit;
    dur_t unit3;
    dur_t unit7;
    pat = morse_of(c);
    unit = dur_t'(dit_len);
    unit3 = dur_t'(unit * 3);
    unit7 = dur_t'(unit * 7);
    for (int k = 0; k < pat.len() && k < 8; k++) begin
      if (k > 0) begin
        segs_due.push_back('{1'b0, unit, 1'b0});
      end
      if (pat[k] == "-") begin
        segs_due.push_back('{1'b1, unit3, 1'b0});
      end else begin
        segs_due.push_back('{1'b1, unit, 1'b0});
      end
    end
    segs_due.push_back('{1'b0, fin ? unit7 : unit3, 1'b1});
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Segments are sampled mid-cycle, away from the edges where they change.
  always @(negedge clk_i) begin
    segment_t want;
    if (rst_ni === 1'b1 && strobe_o === 1'b1) begin
      if (segs_due.size() == 0) begin
        note_failure($sformatf("unexpected segment: tone=%0b dur=%0d last=%0b",
                               tone_on_o, duration_ms_o, last_segment_o));
      end else begin
        want = segs_due.pop_front();
        if (tone_on_o !== want.tone || duration_ms_o !== want.dur ||
            last_segment_o !== want.last) begin
          note_failure($sformatf(
              {"segment mismatch: expected tone=%0b dur=%0d last=%0b, ",
               "got tone=%0b dur=%0d last=%0b"},
              want.tone, want.dur, want.last, tone_on_o, duration_ms_o, last_segment_o));
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepts the item,
  // with start still high.
  task automatic key_char(char_t c, logic fin);
    int gap;
    logic taken;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    char_code_i <= c;
    final_char_i <= fin;
    do begin
      @(negedge clk_i);
      taken = (busy === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    queue_segments_for(c, fin);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dit(dit_t v);
    dit_we_i <= 1'b1;
    dit_wdata_i <= v;
    @(posedge clk_i);
    dit_we_i <= 1'b0;
    dit_len = v;
  endtask

  function automatic char_t pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return keyed_chars[$urandom_range(0, keyed_chars.len() - 1)];
    end else if (r < 80) begin
      return AsciiBackspace;
    end
    return char_t'($urandom_range(0, 255));
  endfunction

  task automatic test_table_corners();
    key_char(8'h00, 1'b0);
    key_char(8'hFF, 1'b1);
    key_char(AsciiBackspace, 1'b0);
    key_char(" ", 1'b1);
    key_char("b", 1'b0);
    key_char("E", 1'b1);
    key_char("T", 1'b0);
    key_char("0", 1'b0);
    key_char("5", 1'b1);
    key_char(8'h27, 1'b0);
    key_char(")", 1'b1);
    key_char(",", 1'b0);
    key_char("?", 1'b0);
    key_char("_", 1'b1);
    key_char("Z", 1'b0);
    key_char(8'h7F, 1'b1);
    key_char(8'h80, 1'b0);
  endtask

  task automatic test_dit_extremes();
    wait_idle();
    write_dit('0);
    key_char(AsciiBackspace, 1'b1);
    key_char("0", 1'b0);
    wait_idle();
    write_dit('1);
    key_char(AsciiBackspace, 1'b0);
    key_char("0", 1'b1);
    wait_idle();
    write_dit(dit_t'(1));
    key_char("Q", 1'b1);
  endtask

  task automatic test_random_text();
    dit_t setting;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: setting = dit_t'($urandom_range(1, 1200));
        1: setting = dit_t'(1200);
        2: setting = dit_t'($urandom_range(0, 2047));
        default: setting = dit_t'($urandom_range(1, 60));
      endcase
      wait_idle();
      write_dit(setting);
      for (int n = 0; n < 80; n++) begin
        if (n % 16 == 0) begin
          max_gap = ($urandom_range(0, 2) == 0) ? 0 : 13;
        end
        key_char(pick_char(), $urandom_range(0, 3) == 0);
      end
    end
    max_gap = 13;
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    char_code_i <= '0;
    final_char_i <= 1'b0;
    dit_we_i <= 1'b0;
    dit_wdata_i <= '0;
    dit_len = mck_pkg::DitReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_corners();
    test_dit_extremes();
    test_random_text();
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
